/* design/kwm_pkg.sv */
// Shared types and constants for the k-way sorted merge block.
// No dependencies.
`default_nettype none
package kwm_pkg;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned SRC_W  = 4;
    localparam int unsigned CNT_W  = 5;

    // one input transaction as it travels from the front to the back part
    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [VAL_W-1:0] val;
        logic             has;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [SRC_W-1:0] src;
        logic             last;
        logic             no_data;
    } t_result;
endpackage
`default_nettype wire

/* design/k_way_sorted_merge.sv */
// Top level of the k-way sorted merge: input queue, heap engine, config register.
// Depends on kwm_pkg, kwm_front, kwm_heap.
//
// channel  direction  handshake                payload
// input    in         push / full              list_index, item_value, has_value
// result   out        pop / empty              merged_value, source_list, last, no_data
// config   in         i_cfg_valid/o_cfg_ready  lists_in_use (5 bits)
//
// An item is taken, then sifted up through the heap (read parent, compare, per
// level) and placed before the decide step; after a pop the tail is moved to the
// root and sifted down (read children, compare, per level) and placed.
// Reset is synchronous; the heap is empty and the first load phase waits.
// A result waits in its own register; a new item is taken only when it has
// been popped. Up to two items queue ahead of the heap engine.
`default_nettype none
module k_way_sorted_merge #(
    parameter int unsigned MAX_LISTS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [3:0]  i_list_index,
    input  wire  [31:0] i_item_value,
    input  wire         i_has_value,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] o_merged_value,
    output logic [3:0]  o_source_list,
    output logic        o_last,
    output logic        o_no_data,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [4:0]  i_cfg_data
);
    localparam int unsigned IDX_W = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;

    logic [kwm_pkg::CNT_W-1:0] r_lists;
    kwm_pkg::t_item            w_in, w_q;
    kwm_pkg::t_result          w_res;
    logic                      w_qv, w_take, w_rv;

    assign o_cfg_ready = 1'b1;

    // hold the lists_in_use register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lists <= 5'd16;
        else if (i_cfg_valid && o_cfg_ready) r_lists <= i_cfg_data;
    end

    assign w_in = '{src: i_list_index, val: i_item_value, has: i_has_value};

    kwm_front #(.DEPTH_W(1)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(w_in), .o_valid(w_qv), .i_take(w_take), .o_item(w_q)
    );

    kwm_heap #(.MAX_LISTS(MAX_LISTS), .IDX_W(IDX_W)) u_heap (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_lists(r_lists),
        .i_valid(w_qv), .o_take(w_take), .i_item(w_q),
        .o_res_valid(w_rv), .i_res_take(pop), .o_res(w_res)
    );

    assign empty          = !w_rv;
    assign o_merged_value = w_res.val;
    assign o_source_list  = w_res.src;
    assign o_last         = w_res.last;
    assign o_no_data      = w_res.no_data;
endmodule
`default_nettype wire

/* design/kwm_front.sv */
// Front part: input queue of accepted transactions ahead of the heap engine.
// Depends on kwm_pkg.
`default_nettype none
module kwm_front #(
    parameter int unsigned DEPTH_W = 1
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    output logic              o_full,
    input  kwm_pkg::t_item    i_item,
    output logic              o_valid,
    input  wire               i_take,
    output kwm_pkg::t_item    o_item
);
    localparam int unsigned DEPTH = 1 << DEPTH_W;

    kwm_pkg::t_item       r_mem [DEPTH];
    logic [DEPTH_W-1:0]   r_wr, r_rd;
    logic [DEPTH_W:0]     r_cnt;
    logic                 w_put, w_get;

    assign o_full  = (r_cnt == (DEPTH_W+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_put   = i_push && !o_full;
    assign w_get   = i_take && o_valid;

    // store transaction
    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_put) r_wr <= r_wr + 1'b1;
            if (w_get) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (DEPTH_W+1)'(w_put) - (DEPTH_W+1)'(w_get);
        end
    end
endmodule
`default_nettype wire

/* design/kwm_heap.sv */
// Back part: min-heap engine, sifting one level per read and compare step, with result register.
// Depends on kwm_pkg.
`default_nettype none
module kwm_heap #(
    parameter int unsigned MAX_LISTS = 16,
    parameter int unsigned IDX_W     = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire [kwm_pkg::CNT_W-1:0]     i_lists,
    input  wire                          i_valid,
    output logic                         o_take,
    input  kwm_pkg::t_item               i_item,
    output logic                         o_res_valid,
    input  wire                          i_res_take,
    output kwm_pkg::t_result             o_res
);
    typedef enum logic [2:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_DECIDE, S_DN_RD, S_DN_CMP
    } t_state;

    localparam int unsigned CW = IDX_W + 1;

    logic [kwm_pkg::VAL_W-1:0] r_hv [MAX_LISTS];
    logic [kwm_pkg::SRC_W-1:0] r_hs [MAX_LISTS];

    t_state                    r_state;
    logic [CW-1:0]             r_count, r_loads;
    logic                      r_loading;
    logic [IDX_W-1:0]          r_i;
    logic [kwm_pkg::VAL_W-1:0] r_cv;    // value being sifted
    logic [kwm_pkg::SRC_W-1:0] r_cs;
    logic [kwm_pkg::VAL_W-1:0] r_pv, r_lv, r_rv;
    logic [kwm_pkg::SRC_W-1:0] r_ps, r_ls, r_rs;
    logic                      r_lok, r_rok;
    kwm_pkg::t_result          r_res;
    logic                      r_res_valid;

    logic [CW-1:0]             w_run;
    logic [CW-1:0]             w_tail;
    logic [CW:0]               w_l, w_r;
    logic                      w_lt_p, w_l_lt_c, w_r_lt_c, w_r_lt_l;

    // strict order on value then source index
    function automatic logic f_less(input logic [kwm_pkg::VAL_W-1:0] av,
                                    input logic [kwm_pkg::SRC_W-1:0] as,
                                    input logic [kwm_pkg::VAL_W-1:0] bv,
                                    input logic [kwm_pkg::SRC_W-1:0] bs);
        if (av != bv) return $signed(av) < $signed(bv);
        return as < bs;
    endfunction

    // clamp lists_in_use to 1..MAX_LISTS
    always_comb begin
        if (i_lists == '0)
            w_run = CW'(1);
        else if ({1'b0, i_lists} > 6'(MAX_LISTS))
            w_run = CW'(MAX_LISTS);
        else
            w_run = CW'(i_lists);
    end

    assign w_tail   = r_count - 1'b1;
    assign w_l      = {1'b0, r_i, 1'b1};
    assign w_r      = w_l + 1'b1;
    assign w_lt_p   = f_less(r_cv, r_cs, r_pv, r_ps);
    assign w_l_lt_c = r_lok && f_less(r_lv, r_ls, r_cv, r_cs);
    assign w_r_lt_c = r_rok && f_less(r_rv, r_rs, r_cv, r_cs);
    assign w_r_lt_l = f_less(r_rv, r_rs, r_lv, r_ls);

    assign o_take      = (r_state == S_IDLE) && i_valid && !r_res_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // heap sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_loads     <= '0;
            r_loading   <= 1'b1;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_take) r_res_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        r_cv <= i_item.val;
                        r_cs <= i_item.src;
                        if (i_item.has && r_count < CW'(MAX_LISTS)) begin
                            r_i     <= r_count[IDX_W-1:0];
                            r_count <= r_count + 1'b1;
                            r_state <= S_UP_RD;
                        end else begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_UP_RD: begin
                    // fetch parent of hole, or place the item if the hole is the root
                    if (r_i == '0) begin
                        r_hv[r_i] <= r_cv;
                        r_hs[r_i] <= r_cs;
                        r_state   <= S_DECIDE;
                    end else begin
                        r_pv    <= r_hv[(r_i - 1'b1) >> 1];
                        r_ps    <= r_hs[(r_i - 1'b1) >> 1];
                        r_state <= S_UP_CMP;
                    end
                end
                S_UP_CMP: begin
                    if (w_lt_p) begin
                        r_hv[r_i] <= r_pv;
                        r_hs[r_i] <= r_ps;
                        r_i       <= (r_i - 1'b1) >> 1;
                        r_state   <= S_UP_RD;
                    end else begin
                        r_hv[r_i] <= r_cv;
                        r_hs[r_i] <= r_cs;
                        r_state   <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_IDLE;
                    if (r_loading && (r_loads + 1'b1) < w_run) begin
                        r_loads <= r_loads + 1'b1;
                    end else if (r_count == '0) begin
                        // empty heap: report no data only at end of a load
                        r_loads   <= '0;
                        r_loading <= 1'b1;
                        if (r_loading) begin
                            r_res       <= '{val: '0, src: '0, last: 1'b1, no_data: 1'b1};
                            r_res_valid <= 1'b1;
                        end
                    end else begin
                        // pop root; if items remain, move tail into root and sift down
                        r_loading <= 1'b0;
                        r_loads   <= '0;
                        r_res     <= '{val: r_hv[0], src: r_hs[0],
                                       last: (r_count == CW'(1)), no_data: 1'b0};
                        r_res_valid <= 1'b1;
                        r_count   <= r_count - 1'b1;
                        if (r_count == CW'(1)) begin
                            r_loading <= 1'b1;
                        end else begin
                            r_cv    <= r_hv[w_tail[IDX_W-1:0]];
                            r_cs    <= r_hs[w_tail[IDX_W-1:0]];
                            r_i     <= '0;
                            r_state <= S_DN_RD;
                        end
                    end
                end
                S_DN_RD: begin
                    // fetch children that lie inside the heap
                    r_lok <= w_l < {1'b0, r_count};
                    r_rok <= w_r < {1'b0, r_count};
                    r_lv  <= r_hv[w_l[IDX_W-1:0]];
                    r_ls  <= r_hs[w_l[IDX_W-1:0]];
                    r_rv  <= r_hv[w_r[IDX_W-1:0]];
                    r_rs  <= r_hs[w_r[IDX_W-1:0]];
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (w_r_lt_c && (!r_lok || w_r_lt_l) && !(w_l_lt_c && !w_r_lt_l)) begin
                        r_hv[r_i] <= r_rv;
                        r_hs[r_i] <= r_rs;
                        r_i       <= w_r[IDX_W-1:0];
                        r_state   <= S_DN_RD;
                    end else if (w_l_lt_c) begin
                        r_hv[r_i] <= r_lv;
                        r_hs[r_i] <= r_ls;
                        r_i       <= w_l[IDX_W-1:0];
                        r_state   <= S_DN_RD;
                    end else begin
                        r_hv[r_i] <= r_cv;
                        r_hs[r_i] <= r_cs;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
